// ===== rtl/core/cpf_pkg.sv =====
package cpf_pkg;

  // framing constants
  localparam int unsigned LENGTH_BITS_DEF = 10;
  localparam int unsigned QUEUE_DEPTH     = 4;

  localparam logic [7:0]  SYNC_BYTE      = 8'h55;
  localparam logic [7:0]  OUTER_ID_BYTE  = 8'hCC;
  localparam logic [7:0]  CRC8_INIT      = 8'h77;
  localparam logic [7:0]  CRC8_POLY      = 8'h8C;
  localparam logic [15:0] CRC16_INIT     = 16'h3692;
  localparam logic [15:0] CRC16_POLY     = 16'h8408;
  localparam logic [10:0] INNER_OVERHEAD = 11'd13;

  // item kinds
  localparam logic CMD_START   = 1'b0;
  localparam logic CMD_PAYLOAD = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic [15:0] channel;
    logic [7:0]  sender;
    logic [7:0]  receiver;
    logic [15:0] sequence_req;
    logic [7:0]  flag_bits;
    logic [7:0]  command_set;
    logic [7:0]  command_id;
    logic [9:0]  payload_length;
    logic [7:0]  data_byte;
  } cmd_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_end;
    logic       run_last;
  } byte_item_t;

  // work entry handed from the front to the back
  typedef struct packed {
    logic        is_start;
    logic        close;
    logic [15:0] channel;
    logic [7:0]  sender;
    logic [7:0]  receiver;
    logic [15:0] sequence_req;
    logic [7:0]  flag_bits;
    logic [7:0]  command_set;
    logic [7:0]  command_id;
    logic [9:0]  payload_length;
    logic [7:0]  data_byte;
  } work_t;

  // reflected crc-8, one byte
  function automatic logic [7:0] crc8_step(input logic [7:0] c, input logic [7:0] b);
    logic [7:0] r;
    r = c ^ b;
    for (int i = 0; i < 8; i++) begin
      r = (r >> 1) ^ (r[0] ? CRC8_POLY : 8'h00);
    end
    return r;
  endfunction

  // reflected crc-16, one byte
  function automatic logic [15:0] crc16_step(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      r = (r >> 1) ^ (r[0] ? CRC16_POLY : 16'h0000);
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/cpf_front.sv =====
module cpf_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  cpf_pkg::cmd_item_t cmd_item,
  input  logic               queue_full,
  output logic               push,
  output cpf_pkg::work_t     push_entry
);
  import cpf_pkg::*;

  logic       frame_open;
  logic       frame_open_next;
  logic [9:0] bytes_left;
  logic [9:0] bytes_left_next;
  logic [9:0] left_dec;
  logic       accept;

  assign cmd_ready = !queue_full;
  assign accept    = cmd_valid && cmd_ready;
  assign left_dec  = bytes_left - 10'd1;

  // classify the item and track the open frame
  always_comb begin
    frame_open_next       = frame_open;
    bytes_left_next       = bytes_left;
    push                  = 1'b0;
    push_entry.is_start   = (cmd_item.cmd == CMD_START);
    push_entry.close      = 1'b0;
    push_entry.channel        = cmd_item.channel;
    push_entry.sender         = cmd_item.sender;
    push_entry.receiver       = cmd_item.receiver;
    push_entry.sequence_req   = cmd_item.sequence_req;
    push_entry.flag_bits      = cmd_item.flag_bits;
    push_entry.command_set    = cmd_item.command_set;
    push_entry.command_id     = cmd_item.command_id;
    push_entry.payload_length = cmd_item.payload_length;
    push_entry.data_byte      = cmd_item.data_byte;
    if (accept) begin
      if (cmd_item.cmd == CMD_START) begin
        push             = 1'b1;
        push_entry.close = (cmd_item.payload_length == 10'd0);
        frame_open_next  = (cmd_item.payload_length != 10'd0);
        bytes_left_next  = cmd_item.payload_length;
      end else if (frame_open) begin
        push             = 1'b1;
        push_entry.close = (left_dec == 10'd0);
        frame_open_next  = (left_dec != 10'd0);
        bytes_left_next  = left_dec;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_open <= 1'b0;
      bytes_left <= '0;
    end else begin
      frame_open <= frame_open_next;
      bytes_left <= bytes_left_next;
    end
  end

endmodule

// ===== rtl/core/cpf_queue.sv =====
module cpf_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  cpf_pkg::work_t push_entry,
  input  logic           pop,
  output logic           full,
  output logic           not_empty,
  output cpf_pkg::work_t head
);
  import cpf_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

  work_t            slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;

  assign full      = (count == (PTR_W+1)'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/cpf_back.sv =====
module cpf_back #(
  parameter int unsigned LENGTH_BITS = cpf_pkg::LENGTH_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                head_valid,
  input  cpf_pkg::work_t      head,
  output logic                pop,
  output logic                byte_valid,
  input  logic                byte_ready,
  output cpf_pkg::byte_item_t byte_item
);
  import cpf_pkg::*;

  // byte positions within a packet
  localparam logic [4:0] POS_VER_LO  = 5'd1;
  localparam logic [4:0] POS_VER_HI  = 5'd2;
  localparam logic [4:0] POS_INNER   = 5'd8;
  localparam logic [4:0] POS_PAYLOAD = 5'd18;
  localparam logic [4:0] POS_CRC_HI  = 5'd20;

  localparam logic [15:0] VER_BIT  = 16'd1 << LENGTH_BITS;
  localparam logic [15:0] LEN_MASK = VER_BIT - 16'd1;
  localparam logic [7:0]  H8_SYNC  = crc8_step(CRC8_INIT, SYNC_BYTE);

  logic [4:0]  pos;
  logic [4:0]  eff;
  logic [4:0]  last_pos;
  logic [7:0]  h8;
  logic [15:0] crc_reg;
  logic [10:0] inner_len;
  logic [15:0] ver;
  logic [7:0]  cur_byte;
  logic        advance;

  assign advance   = head_valid && (!byte_valid || byte_ready);
  assign eff       = head.is_start ? pos : (pos + POS_PAYLOAD);
  assign last_pos  = head.close ? POS_CRC_HI : POS_PAYLOAD;
  assign pop       = advance && (eff == last_pos);
  assign inner_len = {1'b0, head.payload_length} + INNER_OVERHEAD;
  assign ver       = VER_BIT | ({5'b0, inner_len} & LEN_MASK);

  // byte select by position
  always_comb begin
    case (eff)
      5'd0:    cur_byte = SYNC_BYTE;
      5'd1:    cur_byte = OUTER_ID_BYTE;
      5'd2:    cur_byte = head.channel[7:0];
      5'd3:    cur_byte = head.channel[15:8];
      5'd4:    cur_byte = inner_len[7:0];
      5'd5:    cur_byte = {5'b0, inner_len[10:8]};
      5'd8:    cur_byte = SYNC_BYTE;
      5'd9:    cur_byte = ver[7:0];
      5'd10:   cur_byte = ver[15:8];
      5'd11:   cur_byte = h8;
      5'd12:   cur_byte = head.sender;
      5'd13:   cur_byte = head.receiver;
      5'd14:   cur_byte = head.sequence_req[7:0];
      5'd15:   cur_byte = head.sequence_req[15:8];
      5'd16:   cur_byte = head.flag_bits;
      5'd17:   cur_byte = head.command_set;
      5'd18:   cur_byte = head.is_start ? head.command_id : head.data_byte;
      5'd19:   cur_byte = crc_reg[7:0];
      5'd20:   cur_byte = crc_reg[15:8];
      default: cur_byte = 8'h00;
    endcase
  end

  // position counter, header crc-8 and running crc-16
  always_ff @(posedge clk) begin
    if (rst) begin
      pos     <= '0;
      crc_reg <= CRC16_INIT;
    end else if (advance) begin
      pos <= pop ? 5'd0 : (pos + 5'd1);
      if (eff == POS_INNER) begin
        crc_reg <= crc16_step(CRC16_INIT, cur_byte);
      end else if (eff inside {[5'd9:5'd18]}) begin
        crc_reg <= crc16_step(crc_reg, cur_byte);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && eff == POS_VER_LO) begin
      h8 <= crc8_step(H8_SYNC, ver[7:0]);
    end else if (advance && eff == POS_VER_HI) begin
      h8 <= crc8_step(h8, ver[15:8]);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (advance) begin
      byte_valid <= 1'b1;
    end else if (byte_ready) begin
      byte_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      byte_item.out_byte  <= cur_byte;
      byte_item.frame_end <= (eff == POS_CRC_HI);
      byte_item.run_last  <= (eff == last_pos);
    end
  end

endmodule

// ===== rtl/core/crc_packet_framer.sv =====
// Packet framer: turns command items into a framed byte stream.
// cmd channel (cmd_valid/cmd_ready/cmd_item): a start item (cmd = 0) opens a
// frame and yields 19 header bytes, 21 with the two crc bytes when the payload
// length is zero; a payload item (cmd = 1) yields its data byte, plus the two
// crc bytes when it is the last one. Payload items with no frame open are
// taken and dropped.
// byte channel (byte_valid/byte_ready/byte_item): one byte per item, with
// frame_end on the final crc byte and run_last on the last byte of an input
// item.
// With the queue empty, the first byte of an item passes through the work
// queue entry and then the output register before it is on the output.
// Throughput: one output byte per cycle while byte_ready is high, so payload
// items flow at one per cycle; a start item holds the sequencer for its bytes.
// A four-entry work queue sits between the classifying front and the byte
// sequencer; cmd_ready drops only when that queue is full.
// When the receiver stalls, the output register holds its byte and the
// sequencer waits; the front keeps taking items until the queue fills.
// Reset (rst, synchronous) closes any open frame and empties the queue.
module crc_packet_framer #(
  parameter int unsigned LENGTH_BITS = cpf_pkg::LENGTH_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  cpf_pkg::cmd_item_t  cmd_item,
  output logic                byte_valid,
  input  logic                byte_ready,
  output cpf_pkg::byte_item_t byte_item
);
  import cpf_pkg::*;

  logic  push;
  work_t push_entry;
  logic  pop;
  logic  queue_full;
  logic  head_valid;
  work_t head;

  cpf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd_item   (cmd_item),
    .queue_full (queue_full),
    .push       (push),
    .push_entry (push_entry)
  );

  cpf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (queue_full),
    .not_empty  (head_valid),
    .head       (head)
  );

  cpf_back #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .byte_item  (byte_item)
  );

endmodule

// ===== tb/crc_packet_framer_tb.sv =====
`timescale 1ns / 100ps

module crc_packet_framer_tb;
  import cpf_pkg::*;

  localparam int HOLD_CYCLES   = 200;
  localparam int PHASE_ITEMS   = 100;
  localparam int SEND_IDLE[4]  = '{0, 51, 0, 26};
  localparam int RECV_STALL[4] = '{0, 0, 51, 26};

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cmd_valid = 1'b0;
  logic       cmd_ready;
  cmd_item_t  cmd_item = '0;
  logic       byte_valid;
  logic       byte_ready = 1'b0;
  byte_item_t byte_item;

  // items waiting to be offered, and bytes the framer still owes us
  cmd_item_t  cmd_backlog[$];
  byte_item_t exp_bytes[$];

  // framer state as tracked by the predictor
  logic        frame_open = 1'b0;
  logic [9:0]  payload_left = '0;
  logic [15:0] frame_crc = CRC16_INIT;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_asks = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int error_count = 0;
  int byte_count = 0;

  crc_packet_framer u_top (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd_item  (cmd_item),
    .byte_valid(byte_valid),
    .byte_ready(byte_ready),
    .byte_item (byte_item)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // header crc-8, reflected
  function automatic logic [7:0] hdr_crc8(logic [7:0] acc, logic [7:0] b);
    logic [7:0] r;
    r = acc ^ b;
    repeat (8) r = r[0] ? ((r >> 1) ^ CRC8_POLY) : (r >> 1);
    return r;
  endfunction

  // frame crc-16, reflected
  function automatic logic [15:0] frame_crc16(logic [15:0] acc, logic [7:0] b);
    logic [15:0] r;
    r = acc ^ {8'h00, b};
    repeat (8) r = r[0] ? ((r >> 1) ^ CRC16_POLY) : (r >> 1);
    return r;
  endfunction

  function automatic void push_out(logic [7:0] b, logic fe);
    byte_item_t e;
    e.out_byte  = b;
    e.frame_end = fe;
    e.run_last  = 1'b0;
    exp_bytes.push_back(e);
  endfunction

  function automatic void push_inner(logic [7:0] b);
    frame_crc = frame_crc16(frame_crc, b);
    push_out(b, 1'b0);
  endfunction

  function automatic void push_crc();
    push_out(frame_crc[7:0], 1'b0);
    push_out(frame_crc[15:8], 1'b1);
    frame_open   = 1'b0;
    payload_left = '0;
  endfunction

  // expected bytes for one accepted item
  function automatic void predict_frame_bytes(cmd_item_t it);
    int unsigned start_len;
    logic [31:0] inner_len;
    logic [15:0] ver;
    logic [7:0]  h8;
    start_len = exp_bytes.size();
    if (it.cmd == CMD_START) begin
      inner_len = 32'(INNER_OVERHEAD) + 32'(it.payload_length);
      ver = 16'((32'd1 << LENGTH_BITS_DEF)
                | (inner_len & ((32'd1 << LENGTH_BITS_DEF) - 32'd1)));
      h8 = hdr_crc8(hdr_crc8(hdr_crc8(CRC8_INIT, SYNC_BYTE), ver[7:0]), ver[15:8]);
      // outer header
      push_out(SYNC_BYTE, 1'b0);
      push_out(OUTER_ID_BYTE, 1'b0);
      push_out(it.channel[7:0], 1'b0);
      push_out(it.channel[15:8], 1'b0);
      push_out(inner_len[7:0], 1'b0);
      push_out(inner_len[15:8], 1'b0);
      push_out(inner_len[23:16], 1'b0);
      push_out(inner_len[31:24], 1'b0);
      // inner header, covered by the frame crc
      frame_crc = CRC16_INIT;
      push_inner(SYNC_BYTE);
      push_inner(ver[7:0]);
      push_inner(ver[15:8]);
      push_inner(h8);
      push_inner(it.sender);
      push_inner(it.receiver);
      push_inner(it.sequence_req[7:0]);
      push_inner(it.sequence_req[15:8]);
      push_inner(it.flag_bits);
      push_inner(it.command_set);
      push_inner(it.command_id);
      frame_open   = 1'b1;
      payload_left = it.payload_length;
      if (it.payload_length == 10'd0) push_crc();
    end else if (frame_open) begin
      push_inner(it.data_byte);
      payload_left = payload_left - 10'd1;
      if (payload_left == 10'd0) push_crc();
    end
    if (exp_bytes.size() > start_len) exp_bytes[exp_bytes.size() - 1].run_last = 1'b1;
  endfunction

  function automatic cmd_item_t rand_item(logic kind, logic [9:0] plen);
    cmd_item_t it;
    it.cmd            = kind;
    it.channel        = 16'($urandom);
    it.sender         = 8'($urandom);
    it.receiver       = 8'($urandom);
    it.sequence_req   = 16'($urandom);
    it.flag_bits      = 8'($urandom);
    it.command_set    = 8'($urandom);
    it.command_id     = 8'($urandom);
    it.payload_length = plen;
    it.data_byte      = 8'($urandom);
    return it;
  endfunction

  // one frame with random content; returns the number of items that do work
  function automatic int queue_random_frame();
    int unsigned pick;
    int unsigned plen;
    int unsigned nsent;
    pick = $urandom_range(99);
    if (pick < 70) plen = $urandom_range(8);
    else if (pick < 92) plen = $urandom_range(40, 9);
    else plen = $urandom_range(1023, 41);
    nsent = plen;
    // long frames and some short ones are cut off by the next start
    if (plen > 40) nsent = $urandom_range(6);
    else if ($urandom_range(9) == 0) nsent = $urandom_range(plen);
    cmd_backlog.push_back(rand_item(CMD_START, 10'(plen)));
    repeat (nsent) cmd_backlog.push_back(rand_item(CMD_PAYLOAD, 10'($urandom)));
    // stray payload items
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(3, 1)) cmd_backlog.push_back(rand_item(CMD_PAYLOAD, 10'($urandom)));
    end
    return 1 + nsent;
  endfunction

  task automatic wait_drained();
    while (cmd_backlog.size() != 0 || cmd_valid || exp_bytes.size() != 0) @(posedge clk);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else begin
      if (cmd_valid && cmd_ready) predict_frame_bytes(cmd_item);
      if (!cmd_valid || cmd_ready) begin
        if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cmd_valid <= 1'b1;
          cmd_item  <= cmd_backlog.pop_front();
        end else begin
          cmd_valid <= 1'b0;
        end
      end
    end
  end

  // receiver ready, with random stalls and a long hold on request
  always @(posedge clk) begin
    if (hold_asks != hold_seen) begin
      hold_seen  <= hold_asks;
      hold_left  <= HOLD_CYCLES;
      byte_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      byte_ready <= 1'b0;
    end else begin
      byte_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    byte_item_t want;
    if (!rst && byte_valid && byte_ready) begin
      byte_count++;
      if (exp_bytes.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("byte %0d: unexpected item, byte %02h end %0b last %0b", byte_count,
                   byte_item.out_byte, byte_item.frame_end, byte_item.run_last);
      end else begin
        want = exp_bytes.pop_front();
        if (byte_item.out_byte !== want.out_byte || byte_item.frame_end !== want.frame_end
            || byte_item.run_last !== want.run_last) begin
          error_count++;
          if (error_count <= 10)
            $display({"byte %0d: expected byte %02h end %0b last %0b,",
                      " got byte %02h end %0b last %0b"},
                     byte_count, want.out_byte, want.frame_end, want.run_last,
                     byte_item.out_byte, byte_item.frame_end, byte_item.run_last);
        end
      end
    end
  end

  // stimulus
  initial begin
    cmd_item_t it;
    int queued;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // payload with no frame open is dropped
    it = '1;
    it.cmd = CMD_PAYLOAD;
    cmd_backlog.push_back(it);
    // zero-length frames, all fields low then all high
    it = '0;
    it.cmd = CMD_START;
    cmd_backlog.push_back(it);
    it = '1;
    it.cmd = CMD_START;
    it.payload_length = 10'd0;
    cmd_backlog.push_back(it);
    // longest length wraps the version word; abandoned after two bytes
    it.payload_length = 10'd1023;
    cmd_backlog.push_back(it);
    it = '0;
    it.cmd = CMD_PAYLOAD;
    cmd_backlog.push_back(it);
    it = '1;
    cmd_backlog.push_back(it);
    // start over an open frame, first length that wraps
    cmd_backlog.push_back(rand_item(CMD_START, 10'd1011));
    cmd_backlog.push_back(rand_item(CMD_PAYLOAD, 10'd0));
    // complete short frame
    cmd_backlog.push_back(rand_item(CMD_START, 10'd3));
    it = rand_item(CMD_PAYLOAD, 10'd0);
    it.data_byte = 8'h00;
    cmd_backlog.push_back(it);
    it.data_byte = 8'hFF;
    cmd_backlog.push_back(it);
    it.data_byte = 8'h5A;
    cmd_backlog.push_back(it);
    // stray byte after the frame closed
    cmd_backlog.push_back(rand_item(CMD_PAYLOAD, 10'd0));
    // one-byte frame
    cmd_backlog.push_back(rand_item(CMD_START, 10'd1));
    cmd_backlog.push_back(rand_item(CMD_PAYLOAD, 10'h3FF));
    // abandoned mid-frame by a zero-length start
    cmd_backlog.push_back(rand_item(CMD_START, 10'd2));
    cmd_backlog.push_back(rand_item(CMD_PAYLOAD, 10'd0));
    cmd_backlog.push_back(rand_item(CMD_START, 10'd0));
    // largest legal length, closed early by a new start
    cmd_backlog.push_back(rand_item(CMD_START, 10'd1010));
    cmd_backlog.push_back(rand_item(CMD_PAYLOAD, 10'd0));
    cmd_backlog.push_back(rand_item(CMD_START, 10'd0));
    wait_drained();

    // random frames under each idling mix
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = SEND_IDLE[ph];
      recv_stall_pct = RECV_STALL[ph];
      queued = 0;
      while (queued < PHASE_ITEMS) queued += queue_random_frame();
      if (ph == 0) begin
        // long receiver hold so the work queue fills and input stalls
        @(posedge clk);
        hold_asks <= hold_asks + 1;
      end
      wait_drained();
      repeat (4) @(posedge clk);
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (exp_bytes.size() != 0) error_count++;
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/cpf_pkg.sv
rtl/core/cpf_front.sv
rtl/core/cpf_queue.sv
rtl/core/cpf_back.sv
rtl/core/crc_packet_framer.sv
tb/crc_packet_framer_tb.sv
